>>> hw/rtl/tnbm_pkg.sv
// Shared types, constants and arithmetic helpers for the tanh neuron block.
package tnbm_pkg;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_OGRAD = 3'd2,
        CMD_HID   = 3'd3,
        CMD_UPD   = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ACC,
        ST_SUM,
        ST_TIDX,
        ST_TAB,
        ST_DERIV,
        ST_GMUL,
        ST_GRAD,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3,
        ST_UPD4,
        ST_OUT
    } t_state;

    localparam logic [1:0]  CFG_LEARN_RATE = 2'd0;
    localparam logic [1:0]  CFG_MOMENTUM   = 2'd1;
    localparam logic [14:0] LR_RESET       = 15'd614;
    localparam logic [14:0] MOM_RESET      = 15'd2048;
    localparam int          IDX_W          = 6;
    localparam logic [63:0] Q30_ONE        = 64'd1 << 30;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // Round half up, then arithmetic shift right.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    // Restoring division, evaluated only while building the tanh table.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(i*8/depth) in Q4.12 through exp(-2x) from a short series and squarings.
    function automatic logic [15:0] tanh_entry(input int unsigned i, input int unsigned depth);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] z3;
        logic [63:0] z4;
        logic [63:0] z5;
        logic [63:0] e;
        logic [63:0] num;
        z  = udiv64(64'(i) << 26, 64'(depth));
        z2 = (z * z) >> 30;
        z3 = (z2 * z) >> 30;
        z4 = (z3 * z) >> 30;
        z5 = (z4 * z) >> 30;
        e  = (Q30_ONE + z2 / 2 + z4 / 24) - (z + z3 / 6 + z5 / 120);
        for (int k = 0; k < 8; k++) begin
            e = (e * e + (Q30_ONE >> 1)) >> 30;
        end
        num = udiv64((Q30_ONE - e) << 13, Q30_ONE + e);
        return 16'((num + 64'd1) >> 1);
    endfunction

endpackage

>>> hw/rtl/tnbm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module tnbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tanh_neuron_backprop_momentum.sv
// Single tanh neuron: weight and momentum stores, accumulator and training datapath.
//
// Input beats on s_axis carry one command each (tuser): load weight, forward,
// output gradient, hidden gradient or weight update. Every beat yields exactly
// one result beat on m_axis with the command echoed and a done flag in tuser.
// The learning rate and momentum are written on the cfg channel (index 0 and 1),
// which is always ready and is to be used only while the neuron is idle.
//
// Items are processed one at a time. Weights and deltas sit in two RAMs with a
// registered read; each item reads its entry, then steps through one shared
// 33x17 multiplier and ends any write-back before the next item is taken. Load
// and unknown commands go from fetch to output; an update runs four steps;
// forward and hidden elements multiply and accumulate, the last forward one
// looks up tanh, and the last hidden one and an output gradient form the
// derivative, then the gradient. The result sits in an output register, so a
// new item is accepted while the previous result waits; if m_axis stalls, the
// item after that holds in its final step until the register frees up.
// Reset (synchronous, active low) clears the accumulator, activation,
// gradient and all momentum deltas at once and restores the default rates.
module tanh_neuron_backprop_momentum
    import tnbm_pkg::*;
#(
    parameter int N_INPUTS         = 64,
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // fields from bit 0: index[5:0], value[21:6], weight_in[37:22], zero pad
    input  logic [39:0] s_axis_tdata,
    // fields from bit 0: cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // fields from bit 0: result[15:0]
    output logic [15:0] m_axis_tdata,
    // fields from bit 0: kind[2:0], done_res[3]
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    // Only 64 connection numbers can be addressed.
    localparam int MEM_DEPTH = (N_INPUTS < 64) ? N_INPUTS : 64;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int TW        = $clog2(TANH_TABLE_DEPTH);
    localparam int TPW       = 17 + $clog2(TANH_TABLE_DEPTH + 1);

    t_state r_state, n_state;

    logic [2:0]         r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic signed [15:0] r_val;
    logic signed [15:0] r_win;
    logic               r_last;

    logic signed [39:0] r_acc;
    logic signed [15:0] r_act;
    logic signed [15:0] r_grad;
    logic [14:0]        r_lr;
    logic [14:0]        r_mom;
    logic [MEM_DEPTH-1:0] r_dvalid;

    logic signed [49:0] r_prod;
    logic signed [15:0] r_sum;
    logic signed [15:0] r_deriv;
    logic signed [25:0] r_a;
    logic signed [15:0] r_delta;
    logic [TW-1:0]      r_ti;
    logic signed [15:0] r_res;
    logic               r_done;

    logic               r_ovalid;
    logic [15:0]        r_odata;
    logic [2:0]         r_okind;
    logic               r_odone;

    logic               w_accept;
    logic               w_slot_free;
    logic               w_ok;
    logic [AW-1:0]      w_addr;
    logic [15:0]        w_wrd;
    logic [15:0]        w_drd;
    logic signed [15:0] w_w;
    logic signed [15:0] w_old;

    logic               w_mul_en;
    logic signed [32:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic               w_we;
    logic               w_dwe;
    logic [15:0]        w_wwdata;

    logic signed [40:0] w_accsum;
    logic signed [39:0] w_accsat;
    logic signed [15:0] w_sum16;
    logic signed [15:0] w_deriv;
    logic signed [15:0] w_gr;
    logic signed [25:0] w_a_next;
    logic signed [15:0] w_delta;
    logic signed [15:0] w_nw;
    logic [16:0]        w_mag;
    logic [TPW-1:0]     w_tprod;
    logic [TPW-1:0]     w_tfull;
    logic [15:0]        w_tab;
    logic signed [15:0] w_tanh_s;
    logic [15:0]        w_tanh_tab [TANH_TABLE_DEPTH];

    // Constant tanh table over |s| in [0, 8).
    for (genvar g = 0; g < TANH_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [15:0] TV = tanh_entry(32'(g), 32'(TANH_TABLE_DEPTH));
        assign w_tanh_tab[g] = TV;
    end

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_slot_free  = !r_ovalid || m_axis_tready;
    assign o_cfg_ready  = 1'b1;

    assign w_ok   = 32'(r_idx) < 32'(N_INPUTS);
    assign w_addr = AW'(r_idx);

    tnbm_ram #(
        .WIDTH(16),
        .DEPTH(MEM_DEPTH)
    ) u_wram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_addr),
        .i_wdata(w_wwdata),
        .i_re   (w_accept),
        .i_raddr(AW'(s_axis_tdata[5:0])),
        .o_rdata(w_wrd)
    );

    tnbm_ram #(
        .WIDTH(16),
        .DEPTH(MEM_DEPTH)
    ) u_dram (
        .i_clk  (i_clk),
        .i_we   (w_dwe),
        .i_waddr(w_addr),
        .i_wdata(r_delta),
        .i_re   (w_accept),
        .i_raddr(AW'(s_axis_tdata[5:0])),
        .o_rdata(w_drd)
    );

    // Read data stays put until the next accepted beat, so later steps reuse it.
    assign w_w   = w_ok ? signed'(w_wrd) : 16'sd0;
    assign w_old = (w_ok && r_dvalid[w_addr]) ? signed'(w_drd) : 16'sd0;

    // Accumulator add with saturation at 40 bits.
    assign w_accsum = 41'(r_acc) + 41'(signed'(r_prod[31:0]));
    always_comb begin
        if (w_accsum[40] != w_accsum[39]) begin
            w_accsat = w_accsum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
            w_accsat = w_accsum[39:0];
        end
    end

    assign w_sum16  = sat16(rnd_shift(64'(r_acc), 12));
    assign w_deriv  = sat16(64'sd4096 - rnd_shift(64'(r_prod), 12));
    assign w_gr     = sat16(rnd_shift(64'(r_prod), 12));
    assign w_a_next = 26'(rnd_shift(64'(r_prod), 24));
    assign w_delta  = sat16(64'(r_a) + rnd_shift(64'(r_prod), 12));
    assign w_nw     = sat16(64'(w_w) + 64'(r_delta));

    assign w_mag    = r_sum[15] ? (17'd0 - 17'(r_sum)) : 17'(r_sum);
    assign w_tprod  = TPW'(w_mag) * TPW'(TANH_TABLE_DEPTH);
    assign w_tfull  = w_tprod >> 15;
    assign w_tab    = w_tanh_tab[r_ti];
    assign w_tanh_s = r_sum[15] ? -signed'(w_tab) : signed'(w_tab);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                case (r_cmd)
                    CMD_FWD, CMD_HID: n_state = ST_ACC;
                    CMD_OGRAD:        n_state = ST_DERIV;
                    CMD_UPD:          n_state = ST_UPD1;
                    default:          n_state = ST_OUT;
                endcase
            end
            ST_ACC:   n_state = ST_SUM;
            ST_SUM: begin
                if (!r_last) begin
                    n_state = ST_OUT;
                end else if (r_cmd == CMD_FWD) begin
                    n_state = ST_TIDX;
                end else begin
                    n_state = ST_DERIV;
                end
            end
            ST_TIDX:  n_state = ST_TAB;
            ST_TAB:   n_state = ST_OUT;
            ST_DERIV: n_state = ST_GMUL;
            ST_GMUL:  n_state = ST_GRAD;
            ST_GRAD:  n_state = ST_OUT;
            ST_UPD1:  n_state = ST_UPD2;
            ST_UPD2:  n_state = ST_UPD3;
            ST_UPD3:  n_state = ST_UPD4;
            ST_UPD4:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_slot_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Multiplier operands and RAM writes per step.
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_we     = 1'b0;
        w_dwe    = 1'b0;
        w_wwdata = r_win;
        case (r_state)
            ST_FETCH: begin
                case (r_cmd)
                    CMD_LOAD: begin
                        w_we = w_ok;
                    end
                    CMD_FWD: begin
                        w_mul_en = 1'b1;
                        w_mul_a  = 33'(r_val);
                        w_mul_b  = 17'(w_w);
                    end
                    CMD_HID: begin
                        w_mul_en = 1'b1;
                        w_mul_a  = 33'(r_win);
                        w_mul_b  = 17'(r_val);
                    end
                    CMD_OGRAD: begin
                        w_mul_en = 1'b1;
                        w_mul_a  = 33'(r_act);
                        w_mul_b  = 17'(r_act);
                    end
                    CMD_UPD: begin
                        w_mul_en = 1'b1;
                        w_mul_a  = 33'(r_val);
                        w_mul_b  = 17'(r_grad);
                    end
                    default: begin
                        w_mul_en = 1'b0;
                    end
                endcase
            end
            ST_SUM: begin
                // Hidden gradient needs the derivative after the last element.
                if (r_last && r_cmd == CMD_HID) begin
                    w_mul_en = 1'b1;
                    w_mul_a  = 33'(r_act);
                    w_mul_b  = 17'(r_act);
                end
            end
            ST_GMUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = (r_cmd == CMD_OGRAD) ? 33'(17'(r_val) - 17'(r_act)) : 33'(r_sum);
                w_mul_b  = 17'(r_deriv);
            end
            ST_UPD1: begin
                w_mul_en = 1'b1;
                w_mul_a  = 33'(signed'(r_prod[31:0]));
                w_mul_b  = signed'({2'b00, r_lr});
            end
            ST_UPD2: begin
                w_mul_en = 1'b1;
                w_mul_a  = signed'({18'd0, r_mom});
                w_mul_b  = 17'(w_old);
            end
            ST_UPD4: begin
                w_we     = w_ok;
                w_dwe    = w_ok;
                w_wwdata = w_nw;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_acc    <= '0;
            r_act    <= '0;
            r_grad   <= '0;
            r_lr     <= LR_RESET;
            r_mom    <= MOM_RESET;
            r_dvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LEARN_RATE) begin
                    r_lr <= i_cfg_data;
                end else if (i_cfg_index == CFG_MOMENTUM) begin
                    r_mom <= i_cfg_data;
                end
            end
            if (r_state == ST_ACC) begin
                r_acc <= w_accsat;
            end
            if (r_state == ST_SUM && r_last) begin
                r_acc <= '0;
            end
            if (r_state == ST_TAB) begin
                r_act <= w_tanh_s;
            end
            if (r_state == ST_GRAD) begin
                r_grad <= w_gr;
            end
            if (r_state == ST_UPD4 && w_ok) begin
                r_dvalid[w_addr] <= 1'b1;
            end
            if (r_state == ST_OUT && w_slot_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= s_axis_tuser;
            r_idx  <= s_axis_tdata[5:0];
            r_val  <= signed'(s_axis_tdata[21:6]);
            r_win  <= signed'(s_axis_tdata[37:22]);
            r_last <= s_axis_tlast;
        end
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        case (r_state)
            ST_FETCH: begin
                r_res  <= (r_cmd == CMD_LOAD) ? r_win : 16'sd0;
                r_done <= 1'b0;
            end
            ST_SUM: begin
                r_sum  <= w_sum16;
                r_res  <= w_sum16;
                r_done <= r_last;
            end
            ST_TIDX: begin
                r_ti <= (w_tfull > TPW'(TANH_TABLE_DEPTH - 1)) ?
                        TW'(TANH_TABLE_DEPTH - 1) : TW'(w_tfull);
            end
            ST_TAB: begin
                r_res <= w_tanh_s;
            end
            ST_DERIV: begin
                r_deriv <= w_deriv;
            end
            ST_GRAD: begin
                r_res  <= w_gr;
                r_done <= 1'b1;
            end
            ST_UPD2: begin
                r_a <= w_a_next;
            end
            ST_UPD3: begin
                r_delta <= w_delta;
            end
            ST_UPD4: begin
                r_res  <= w_nw;
                r_done <= 1'b0;
            end
            default: begin
            end
        endcase
        if (r_state == ST_OUT && w_slot_free) begin
            r_odata <= r_res;
            r_okind <= r_cmd;
            r_odone <= r_done;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = {r_odone, r_okind};

endmodule

>>> hw/rtl/tnbm_chk.sv
// Port-level checker for the tanh neuron, bound to the top level.
module tnbm_chk
    import tnbm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // One item at a time: an accepted beat closes the input for the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    // Only forward and gradient commands can finish a result.
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            (m_axis_tuser[2:0] == CMD_FWD || m_axis_tuser[2:0] == CMD_OGRAD ||
             m_axis_tuser[2:0] == CMD_HID))
        else $error("done flag on a command that cannot finish");

    // An output gradient is always final.
    a_ograd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == CMD_OGRAD |-> m_axis_tuser[3])
        else $error("output gradient without done flag");

endmodule

bind tanh_neuron_backprop_momentum tnbm_chk u_tnbm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
);
